@@ hw/rtl/sssc_pkg.sv @@
// Package for the sorted-set subset check unit.
// Opcodes, sequencer states and default sizes. No dependencies.
package sssc_pkg;

  localparam int unsigned StoreDepthDefault = 1024;
  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned CountWidth        = 16;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_TEST   = 2'd2,
    OP_FINISH = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT
  } state_e;

endpackage

@@ hw/rtl/sorted_set_subset_check_unit.sv @@
// Sorted-set subset check unit: one result per finish command.
// Uses sssc_pkg and sssc_store.
//
// Commands are taken while busy is low. Clear and finish leave busy low;
// finish raises result_valid_o for one cycle in the following cycle and the
// receiver cannot hold it off. A test runs a binary search over the stored
// values, each probe a memory read followed by a compare. An add finds its
// place the same way and then moves every larger entry up by one, a read and
// then a write per moved entry; an add to a full store only sets the overflow
// flag. No clearing pass is needed after reset.
module sorted_set_subset_check_unit #(
  parameter int unsigned STORE_DEPTH = sssc_pkg::StoreDepthDefault,
  parameter int unsigned VALUE_WIDTH = sssc_pkg::ValueWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode_i,
  input  logic signed [31:0]          value_i,
  output logic                        result_valid_o,
  output logic                        is_subset_o,
  output logic                        store_overflowed_o,
  output logic [sssc_pkg::CountWidth-1:0] tested_count_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CNW = sssc_pkg::CountWidth;
  localparam logic [CNW-1:0] CntMax = {CNW{1'b1}};
  localparam logic [CW-1:0] DepthC = CW'(STORE_DEPTH);

  sssc_pkg::state_e state_q, state_d;
  logic [CW-1:0]  count_q, count_d, lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d, wdata;
  logic           is_add_q, is_add_d, hit_q, hit_d;
  logic           found_q, found_d, ovf_q, ovf_d;
  logic [CNW-1:0] tcnt_q, tcnt_d;
  logic           res_q, res_d, we;
  logic [AW-1:0]  waddr, raddr;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [CW-1:0]  mid;
  logic [VALUE_WIDTH-1:0] in_key;

  logic [63:0] val_ext;
  assign val_ext = 64'(value_i);
  // sign bit flipped so unsigned order matches signed order
  assign in_key  = val_ext[VALUE_WIDTH-1:0] ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);

  sssc_store #(.Depth(STORE_DEPTH), .Width(VALUE_WIDTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sssc_pkg::ST_IDLE;
      count_q <= '0;
      found_q <= 1'b1;
      ovf_q   <= 1'b0;
      tcnt_q  <= '0;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      found_q <= found_d;
      ovf_q   <= ovf_d;
      tcnt_q  <= tcnt_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    ptr_q    <= ptr_d;
    key_q    <= key_d;
    is_add_q <= is_add_d;
    hit_q    <= hit_d;
    is_subset_o        <= res_d ? found_q : is_subset_o;
    store_overflowed_o <= res_d ? ovf_q : store_overflowed_o;
    tested_count_o     <= res_d ? tcnt_q : tested_count_o;
  end

  assign busy           = (state_q != sssc_pkg::ST_IDLE);
  assign result_valid_o = res_q;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    found_d  = found_q;
    ovf_d    = ovf_q;
    tcnt_d   = tcnt_q;
    res_d    = 1'b0;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ptr_d    = ptr_q;
    key_d    = key_q;
    is_add_d = is_add_q;
    hit_d    = hit_q;
    we       = 1'b0;
    waddr    = ptr_q[AW-1:0];
    wdata    = rdata;
    raddr    = mid[AW-1:0];
    case (state_q)
      sssc_pkg::ST_IDLE: begin
        if (start) begin
          key_d = in_key;
          lo_d  = '0;
          hi_d  = count_q;
          hit_d = 1'b0;
          case (sssc_pkg::opcode_e'(opcode_i))
            sssc_pkg::OP_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
              found_d = 1'b1;
              tcnt_d  = '0;
            end
            sssc_pkg::OP_ADD: begin
              is_add_d = 1'b1;
              if (count_q >= DepthC) begin
                ovf_d = 1'b1;
              end else begin
                state_d = sssc_pkg::ST_PROBE;
              end
            end
            sssc_pkg::OP_TEST: begin
              is_add_d = 1'b0;
              if (tcnt_q != CntMax) begin
                tcnt_d = tcnt_q + 1'b1;
              end
              state_d = sssc_pkg::ST_PROBE;
            end
            default: begin
              res_d   = 1'b1;
              found_d = 1'b1;
              tcnt_d  = '0;
            end
          endcase
        end
      end
      sssc_pkg::ST_PROBE: begin
        // read of entry mid issued here; lo < hi and the hit flag decide if search is done
        if (lo_q < hi_q && !hit_q) begin
          state_d = sssc_pkg::ST_CMP;
        end else if (is_add_q) begin
          ptr_d   = count_q;
          state_d = (count_q == lo_q) ? sssc_pkg::ST_INSERT : sssc_pkg::ST_SHIFT_RD;
        end else begin
          if (!hit_q) begin
            found_d = 1'b0;
          end
          state_d = sssc_pkg::ST_IDLE;
        end
      end
      sssc_pkg::ST_CMP: begin
        if (!is_add_q && rdata == key_q) begin
          hit_d = 1'b1;
        end else if (rdata > key_q) begin
          hi_d = mid;
        end else begin
          lo_d = mid + 1'b1;
        end
        state_d = sssc_pkg::ST_PROBE;
      end
      sssc_pkg::ST_SHIFT_RD: begin
        raddr   = AW'(ptr_q - 1'b1);
        state_d = sssc_pkg::ST_SHIFT_WR;
      end
      sssc_pkg::ST_SHIFT_WR: begin
        // entry ptr-1 moves up to ptr
        we      = 1'b1;
        wdata   = rdata;
        ptr_d   = ptr_q - 1'b1;
        state_d = (ptr_d == lo_q) ? sssc_pkg::ST_INSERT : sssc_pkg::ST_SHIFT_RD;
      end
      sssc_pkg::ST_INSERT: begin
        we      = 1'b1;
        waddr   = lo_q[AW-1:0];
        wdata   = key_q;
        count_d = count_q + 1'b1;
        state_d = sssc_pkg::ST_IDLE;
      end
      default: state_d = sssc_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/sssc_store.sv @@
// Sorted reference memory: one write port, one registered read port.
// Depends on nothing but its parameters.
module sssc_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/sssc_checker.sv @@
// Port-level checks for the subset check unit, bound to the top level.
// Uses sssc_pkg.
module sssc_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode_i,
  input logic        result_valid_o,
  input logic        is_subset_o,
  input logic [15:0] tested_count_o
);

  // a result follows exactly one accepted finish
  a_res_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && opcode_i == sssc_pkg::OP_FINISH))
    else $error("result without finish");

  a_finish_gives_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == sssc_pkg::OP_FINISH) |=> result_valid_o)
    else $error("finish without result");

  // zero tests means nothing could have missed
  a_zero_tests_yes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && tested_count_o == 16'd0) |-> is_subset_o)
    else $error("no tests but not subset");

  a_clear_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == sssc_pkg::OP_CLEAR ||
     opcode_i == sssc_pkg::OP_FINISH)) |=> !busy)
    else $error("clear or finish left unit busy");

endmodule

bind sorted_set_subset_check_unit sssc_port_checker u_sssc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .opcode_i       (opcode_i),
  .result_valid_o (result_valid_o),
  .is_subset_o    (is_subset_o),
  .tested_count_o (tested_count_o)
);
